FILE: design/u8dec_pkg.sv
// u8dec_pkg: shared widths, status codes and lead byte limits for the utf-8 decoder
// no dependencies; imported by utf8_stream_decoder and u8dec_checker
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

  localparam int BYTE_W   = 8;
  localparam int CP_W     = 21;
  localparam int LEN_W    = 3;
  localparam int STATUS_W = 2;
  localparam int LEFT_W   = 2;
  localparam int OUT_W    = CP_W + LEN_W;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [CP_W-1:0]     cp_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [LEFT_W-1:0]   left_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_END   = 2'd1;
  localparam status_t ST_TRUNC = 2'd2;

  localparam byte_t LEAD4_MIN = 8'hF0;
  localparam byte_t LEAD3_MIN = 8'hE0;
  localparam byte_t ASCII_MAX = 8'h7F;

  localparam len_t LEN_0 = 3'd0;
  localparam len_t LEN_1 = 3'd1;
  localparam len_t LEN_2 = 3'd2;
  localparam len_t LEN_3 = 3'd3;
  localparam len_t LEN_4 = 3'd4;

endpackage

`default_nettype wire

FILE: design/utf8_stream_decoder.sv
// utf8_stream_decoder: lax utf-8 byte stream to code point decoder, stream in and out
// depends on u8dec_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one utf-8 byte per input beat and gives one result beat per complete
// sequence, carrying the code point and the sequence length in out_tdata and a
// status in out_tuser (ok, end for a zero byte at a sequence start, truncated for
// a zero byte inside a sequence). Leads are classed by their top bits only and
// continuation bytes are not checked. The block takes one byte every cycle
// while out_tready does not stall it: a byte passes an input register, then
// the decode logic and the sequence state (bytes left, accumulator, length)
// update as it moves into the result register. Input and result registers
// let a new byte be taken while a finished result waits for out_tready.
module utf8_stream_decoder (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  u8dec_pkg::byte_t       in_tdata,   // [7:0] in_byte
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [u8dec_pkg::OUT_W-1:0]  out_tdata,  // [20:0] code_point, [23:21] seq_length
  output u8dec_pkg::status_t           out_tuser   // [1:0] status
);
  import u8dec_pkg::*;

  // input register
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r,  s1_byte_nxt;

  // sequence state
  left_t bytes_left_r, bytes_left_nxt;
  cp_t   acc_r,        acc_nxt;
  len_t  total_len_r,  total_len_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  cp_t     out_cp_r,    out_cp_nxt;
  len_t    out_len_r,   out_len_nxt;
  status_t out_st_r,    out_st_nxt;

  logic    out_free;
  logic    s1_fire;
  logic    emit;
  cp_t     emit_cp;
  len_t    emit_len;
  status_t emit_st;
  cp_t     acc_shift;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign acc_shift = {acc_r[CP_W-7:0], s1_byte_r[5:0]};

  always_comb begin
    emit           = 1'b0;
    emit_cp        = '0;
    emit_len       = LEN_0;
    emit_st        = ST_OK;
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    total_len_nxt  = total_len_r;
    if (bytes_left_r == '0) begin
      if (s1_byte_r == '0) begin
        emit    = 1'b1;
        emit_st = ST_END;
      end else if (s1_byte_r <= ASCII_MAX) begin
        emit     = 1'b1;
        emit_cp  = cp_t'(s1_byte_r);
        emit_len = LEN_1;
      end else if (s1_byte_r >= LEAD4_MIN) begin
        acc_nxt        = cp_t'(s1_byte_r[2:0]);
        bytes_left_nxt = 2'd3;
        total_len_nxt  = LEN_4;
      end else if (s1_byte_r >= LEAD3_MIN) begin
        acc_nxt        = cp_t'(s1_byte_r[3:0]);
        bytes_left_nxt = 2'd2;
        total_len_nxt  = LEN_3;
      end else begin
        // stray continuation bytes land here too
        acc_nxt        = cp_t'(s1_byte_r[4:0]);
        bytes_left_nxt = 2'd1;
        total_len_nxt  = LEN_2;
      end
    end else if (s1_byte_r == '0) begin
      emit           = 1'b1;
      emit_st        = ST_TRUNC;
      bytes_left_nxt = '0;
      acc_nxt        = '0;
      total_len_nxt  = LEN_0;
    end else if (bytes_left_r == 2'd1) begin
      emit           = 1'b1;
      emit_cp        = acc_shift;
      emit_len       = total_len_r;
      bytes_left_nxt = '0;
      acc_nxt        = '0;
      total_len_nxt  = LEN_0;
    end else begin
      acc_nxt        = acc_shift;
      bytes_left_nxt = bytes_left_r - 2'd1;
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_byte_nxt   = s1_byte_r;
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    out_len_nxt   = out_len_r;
    out_st_nxt    = out_st_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_tdata;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_fire) begin
      out_valid_nxt = emit;
      out_cp_nxt    = emit_cp;
      out_len_nxt   = emit_len;
      out_st_nxt    = emit_st;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      bytes_left_r <= '0;
      acc_r        <= '0;
      total_len_r  <= LEN_0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        bytes_left_r <= bytes_left_nxt;
        acc_r        <= acc_nxt;
        total_len_r  <= total_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    out_cp_r  <= out_cp_nxt;
    out_len_r <= out_len_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_cp_r};
  assign out_tuser  = out_st_r;

endmodule

`default_nettype wire

FILE: design/u8dec_checker.sv
// u8dec_checker: port-level assertions for utf8_stream_decoder, bound into each utf8_stream_decoder
// depends on u8dec_pkg and utf8_stream_decoder
`timescale 1ns / 1ps
`default_nettype none

module u8dec_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [u8dec_pkg::OUT_W-1:0]   out_tdata,
  input wire u8dec_pkg::status_t      out_tuser
);
  import u8dec_pkg::*;

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // end and truncated beats carry no code point and no length
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_END || out_tuser == ST_TRUNC) |-> out_tdata == '0)
    else $error("end or truncated beat with nonzero data");

  // ok beats have a length of one to four bytes
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK |->
      out_tdata[OUT_W-1:CP_W] != LEN_0 && out_tdata[OUT_W-1:CP_W] <= LEN_4)
    else $error("ok beat with bad length");

  // a one-byte sequence is plain ascii
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK && out_tdata[OUT_W-1:CP_W] == LEN_1 |->
      out_tdata[CP_W-1:7] == '0 && out_tdata[6:0] != '0)
    else $error("one-byte sequence outside ascii range");

endmodule

bind utf8_stream_decoder u8dec_checker u_u8dec_checker (.*);

`default_nettype wire
